### src/cswp_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the cycle synced waveform player
package cswp_pkg;

   localparam int CSWP_WAVE_DEPTH = 1024;

   localparam int MODE_W       = 2;
   localparam int ADDR_FIELD_W = 10;
   localparam int SAMPLE_W     = 12;
   localparam int LEN_W        = 11;
   localparam int STATUS_W     = 2;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 16;

   localparam logic [LEN_W-1:0] WAVE_LENGTH_RESET = 11'd1024;

   // request kinds
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CYCLE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ENABLE = 2'd3;

   // player states
   localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RUNNING  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_WAITING  = 2'd2;

   // dac update kinds
   localparam logic [1:0] DAC_HOLD = 2'd0;
   localparam logic [1:0] DAC_ZERO = 2'd1;
   localparam logic [1:0] DAC_LOAD = 2'd2;

   // register index bit of csr_paddr
   localparam logic REG_WAVE_LENGTH = 1'b0;

   typedef struct packed {
      logic [1:0]          dac_op;
      logic [STATUS_W-1:0] status;
   } step_info_type;

endpackage

### src/cycle_synced_waveform_player_unit.sv
`timescale 1ns / 1ps
// top level of the cycle synced waveform player
//
//  port group | direction | contents
//  req_*      | in        | requests: tuser mode, tdata sample_addr/sample_value/enable_value
//  rsp_*      | out       | results: tdata dac_value/dac_written/play_status
//  csr_*      | in/out    | apb register wave_length at byte address 0
//
// one request per cycle sustained while req_tready is high; a result passes the read stage, then the response register
// the sample memory is read at the request edge, the read data sets the dac level
// after reset a clearing sweep over all WAVE_DEPTH words zeroes the memory, req_tready low
// a stalled response holds the read stage, then req_tready drops
module cycle_synced_waveform_player_unit
   import cswp_pkg::*;
#(
   parameter int WAVE_DEPTH = CSWP_WAVE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [MODE_W-1:0]     req_tuser,   // mode
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_addr, sample_value, enable_value, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // dac_value, dac_written, play_status, pad
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(WAVE_DEPTH);

   logic                accept;
   logic                stage_ready;
   logic                clear_busy;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;
   logic [SAMPLE_W-1:0] rd_data;
   step_info_type       step_info;

   assign req_tready = stage_ready & ~clear_busy;
   assign accept     = req_tvalid & req_tready;
   assign csr_pready = 1'b1;

   cswp_seq #(
      .WAVE_DEPTH(WAVE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_tuser),
      .sample_addr (req_tdata[9:0]),
      .sample_value(req_tdata[21:10]),
      .enable_value(req_tdata[22]),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .step_info   (step_info)
   );

   cswp_wave_mem #(
      .WAVE_DEPTH(WAVE_DEPTH)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_en     (mem_re),
      .rd_addr   (mem_raddr),
      .rd_data   (rd_data),
      .clear_busy(clear_busy)
   );

   cswp_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .step_info  (step_info),
      .rd_data    (rd_data),
      .stage_ready(stage_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### src/cswp_wave_mem.sv
`timescale 1ns / 1ps
// waveform sample memory with clearing sweep after reset
module cswp_wave_mem
   import cswp_pkg::*;
#(
   parameter int WAVE_DEPTH = CSWP_WAVE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(WAVE_DEPTH)-1:0] wr_addr,
   input  logic [SAMPLE_W-1:0]           wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(WAVE_DEPTH)-1:0] rd_addr,
   output logic [SAMPLE_W-1:0]           rd_data,
   output logic                          clear_busy
);

   localparam int AW = $clog2(WAVE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WAVE_DEPTH - 1);

   logic [SAMPLE_W-1:0] mem [WAVE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [AW-1:0]       clr_addr_ff;
   logic                clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

### src/cswp_seq.sv
`timescale 1ns / 1ps
// player sequencer: state, index, flags, csr and memory access decode
module cswp_seq
   import cswp_pkg::*;
#(
   parameter int WAVE_DEPTH = CSWP_WAVE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [MODE_W-1:0]             mode,
   input  logic [ADDR_FIELD_W-1:0]       sample_addr,
   input  logic [SAMPLE_W-1:0]           sample_value,
   input  logic                          enable_value,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          mem_we,
   output logic [$clog2(WAVE_DEPTH)-1:0] mem_waddr,
   output logic [SAMPLE_W-1:0]           mem_wdata,
   output logic                          mem_re,
   output logic [$clog2(WAVE_DEPTH)-1:0] mem_raddr,
   output step_info_type                 step_info
);

   localparam int AW = $clog2(WAVE_DEPTH);
   localparam int IW = $clog2(WAVE_DEPTH + 1);
   localparam int CW = (IW > LEN_W) ? IW : LEN_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(WAVE_DEPTH);

   logic [LEN_W-1:0]    wave_length_ff;
   logic [STATUS_W-1:0] state_ff, state_in;
   logic [IW-1:0]       index_ff, index_in;
   logic                pending_ff, pending_in;
   logic                enable_ff, enable_in;

   logic [CW-1:0] wl_ext;
   logic [IW-1:0] eff_len;
   logic [IW-1:0] cur_idx;
   logic [IW-1:0] cur_idx_next;
   logic [1:0]    dac_op;
   logic          csr_wr;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_length_ff <= WAVE_LENGTH_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_WAVE_LENGTH) begin
         wave_length_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_WAVE_LENGTH) ?
                       CSR_DATA_W'(wave_length_ff) : '0;

   always_comb begin
      wl_ext = CW'(wave_length_ff);
      if (wave_length_ff == '0) begin
         eff_len = IW'(1);
      end else if (wl_ext > DEPTH_C) begin
         eff_len = IW'(WAVE_DEPTH);
      end else begin
         eff_len = IW'(wl_ext);
      end
   end

   assign cur_idx      = pending_ff ? '0 : index_ff;
   assign cur_idx_next = cur_idx + 1'b1;

   always_comb begin
      state_in   = state_ff;
      index_in   = index_ff;
      pending_in = pending_ff;
      enable_in  = enable_ff;
      dac_op     = DAC_HOLD;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      mem_we     = 1'b0;
      if (accept) begin
         unique case (mode)
            MODE_TICK: begin
               priority case (state_ff)
                  ST_RUNNING: begin
                     if (!enable_ff) begin
                        state_in = ST_DISABLED;
                        dac_op   = DAC_ZERO;
                     end else begin
                        pending_in = 1'b0;
                        if (cur_idx >= eff_len) begin
                           index_in = cur_idx;
                           state_in = ST_WAITING;
                        end else begin
                           dac_op    = DAC_LOAD;
                           mem_re    = 1'b1;
                           mem_raddr = cur_idx[AW-1:0];
                           index_in  = cur_idx_next;
                           if (cur_idx_next >= eff_len) begin
                              state_in = ST_WAITING;
                           end
                        end
                     end
                  end
                  ST_WAITING: begin
                     if (!enable_ff) begin
                        state_in = ST_DISABLED;
                        dac_op   = DAC_ZERO;
                     end else if (pending_ff) begin
                        pending_in = 1'b0;
                        dac_op     = DAC_LOAD;
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        index_in   = IW'(1);
                        state_in   = (eff_len > IW'(1)) ? ST_RUNNING : ST_WAITING;
                     end
                  end
                  default: begin
                     state_in = ST_DISABLED;
                     if (enable_ff) begin
                        index_in = '0;
                        state_in = ST_WAITING;
                     end
                  end
               endcase
            end
            MODE_CYCLE: pending_in = 1'b1;
            MODE_WRITE: mem_we = (CW'(sample_addr) < DEPTH_C);
            MODE_ENABLE: enable_in = enable_value;
         endcase
      end
   end

   assign mem_waddr = AW'(sample_addr);
   assign mem_wdata = sample_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_DISABLED;
         index_ff   <= '0;
         pending_ff <= 1'b0;
         enable_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         index_ff   <= index_in;
         pending_ff <= pending_in;
         enable_ff  <= enable_in;
      end
   end

   assign step_info.dac_op = dac_op;
   assign step_info.status = state_in;

endmodule

### src/cswp_rsp.sv
`timescale 1ns / 1ps
// read stage and response register holding the dac level
module cswp_rsp
   import cswp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  step_info_type         step_info,
   input  logic [SAMPLE_W-1:0]   rd_data,
   output logic                  stage_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                s1_valid_ff;
   step_info_type       s1_info_ff;
   logic                out_valid_ff;
   logic [SAMPLE_W-1:0] dac_ff, dac_in;
   logic                written_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                advance;

   assign advance     = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign stage_ready = ~s1_valid_ff | ~out_valid_ff | rsp_tready;

   always_comb begin
      unique case (s1_info_ff.dac_op)
         DAC_ZERO: dac_in = '0;
         DAC_LOAD: dac_in = rd_data;
         default:  dac_in = dac_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         dac_ff       <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            dac_ff       <= dac_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= step_info;
      end
      if (advance) begin
         written_ff <= (s1_info_ff.dac_op != DAC_HOLD);
         status_ff  <= s1_info_ff.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, status_ff, written_ff, dac_ff};

endmodule

### src/cswp_checker.sv
`timescale 1ns / 1ps
// port checker for the cycle synced waveform player and its bind
module cswp_checker
   import cswp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_pready
);

   // stalled response stays and holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // reset empties the pipe and starts the memory sweep
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("not idle after reset");

   // a disabled player drives the dac to zero
   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14:13] == ST_DISABLED |-> rsp_tdata[11:0] == '0)
      else $error("dac level not zero while disabled");

   // the csr port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("csr not ready");

endmodule

bind cycle_synced_waveform_player_unit cswp_checker u_cswp_checker (.*);
